@@ rtl/wacc_pkg.sv @@
// Shared constants, opcode codes and controller/datapath command type for the
// wide accumulator ALU. No dependencies.
`default_nettype none

package wacc_pkg;

	localparam int LIMBS      = 8;
	localparam int LIMB_WIDTH = 32;
	localparam int FUNC_W     = 3;
	localparam int IDX_W      = 3;
	localparam int CNT_W      = $clog2(LIMBS);
	localparam int SHAMT_W    = $clog2(LIMB_WIDTH);

	typedef logic [FUNC_W-1:0]     func_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [LIMB_WIDTH-1:0] limb_t;

	localparam func_t FN_LOAD_A = 3'd0;
	localparam func_t FN_LOAD_B = 3'd1;
	localparam func_t FN_ADD_W  = 3'd2;
	localparam func_t FN_ADD_B  = 3'd3;
	localparam func_t FN_MUL    = 3'd4;
	localparam func_t FN_SHL    = 3'd5;
	localparam func_t FN_CMP    = 3'd6;
	localparam func_t FN_READ   = 3'd7;

	typedef struct packed {
		logic start;   // latch a limb-serial op
		logic single;  // op with no limb steps, result straight to output
		logic step;    // process one limb
		logic finish;  // move limb-serial result to output
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/wacc_req_if.sv @@
// Request channel: opcode, limb index and value word.
// Depends on wacc_pkg.
`default_nettype none

interface wacc_req_if;
	logic               valid;
	logic               ready;
	wacc_pkg::func_t    func;
	wacc_pkg::idx_t     limb_index;
	logic [31:0]        value;

	modport source(output valid, output func, output limb_index, output value, input ready);
	modport sink(input valid, input func, input limb_index, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/wacc_rsp_if.sv @@
// Response channel: read data, compare flag and carry flag.
// Depends on wacc_pkg.
`default_nettype none

interface wacc_rsp_if;
	logic               valid;
	logic               ready;
	logic [31:0]        limb_data;
	logic               greater_or_equal;
	logic               carry_out;

	modport source(output valid, output limb_data, output greater_or_equal,
		output carry_out, input ready);
	modport sink(input valid, input limb_data, input greater_or_equal,
		input carry_out, output ready);
endinterface

`default_nettype wire

@@ rtl/wacc_ctrl.sv @@
// Sequencer for the wide accumulator: handshakes and limb step count.
// Depends on wacc_pkg.
`default_nettype none

module wacc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire wacc_pkg::func_t req_func,
	output logic                 req_ready,
	input  wire logic            rsp_ready,
	output logic                 rsp_valid,
	output wacc_pkg::cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                 state_q;
	logic [wacc_pkg::CNT_W-1:0] cnt_q;
	logic                       rsp_valid_q;
	logic                       out_free;
	logic                       accept;
	logic                       serial_op;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign serial_op = (req_func != wacc_pkg::FN_LOAD_A) &&
		(req_func != wacc_pkg::FN_LOAD_B) && (req_func != wacc_pkg::FN_READ);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.start  = accept && serial_op;
		cmd.single = accept && !serial_op;
		cmd.step   = (state_q == ST_RUN);
		cmd.finish = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.single || cmd.finish)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd.start)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == wacc_pkg::CNT_W'(wacc_pkg::LIMBS - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/wacc_dp.sv @@
// Datapath: accumulator and operand limb rings, shared 32-bit limb unit,
// output register. Depends on wacc_pkg.
`default_nettype none

module wacc_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire wacc_pkg::cmd_t  cmd,
	input  wire wacc_pkg::func_t req_func,
	input  wire wacc_pkg::idx_t  req_limb_index,
	input  wire wacc_pkg::limb_t req_value,
	output wacc_pkg::limb_t      rsp_limb_data,
	output logic                 rsp_ge,
	output logic                 rsp_carry
);

	localparam int W = wacc_pkg::LIMB_WIDTH;

	wacc_pkg::limb_t acc_q [wacc_pkg::LIMBS];
	wacc_pkg::limb_t opb_q [wacc_pkg::LIMBS];
	wacc_pkg::func_t func_q;
	wacc_pkg::limb_t val_q;
	wacc_pkg::limb_t cy_q;
	logic            ge_q;
	wacc_pkg::limb_t data_q;
	logic            ge_out_q;
	logic            carry_out_q;

	wacc_pkg::limb_t a;
	wacc_pkg::limb_t b;
	wacc_pkg::limb_t addend;
	logic [W:0]      sum;
	logic [2*W-1:0]  prod;
	logic [2*W-1:0]  shl;
	wacc_pkg::limb_t res;
	wacc_pkg::limb_t cy_d;
	logic            ge_d;

	always_comb begin
		a      = acc_q[0];
		b      = opb_q[0];
		addend = (func_q == wacc_pkg::FN_ADD_B) ? b : val_q;
		sum    = {1'b0, a} + {1'b0, addend} + {{W{1'b0}}, cy_q[0]};
		prod   = {{W{1'b0}}, a} * {{W{1'b0}}, val_q} + {{W{1'b0}}, cy_q};
		shl    = {a, cy_q} << val_q[wacc_pkg::SHAMT_W-1:0];
		res    = a;
		cy_d   = cy_q;
		ge_d   = ge_q;
		case (func_q)
			wacc_pkg::FN_ADD_W, wacc_pkg::FN_ADD_B: begin
				res  = sum[W-1:0];
				cy_d = {{(W-1){1'b0}}, sum[W]};
			end
			wacc_pkg::FN_MUL: begin
				res  = prod[W-1:0];
				cy_d = prod[2*W-1:W];
			end
			wacc_pkg::FN_SHL: begin
				res  = shl[2*W-1:W];
				cy_d = a;
			end
			wacc_pkg::FN_CMP: begin
				// limbs arrive low to high, so a higher unequal limb overrides
				if (a > b)
					ge_d = 1'b1;
				else if (a < b)
					ge_d = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wacc_pkg::LIMBS; i++) begin
				acc_q[i] <= '0;
				opb_q[i] <= '0;
			end
		end else if (cmd.step) begin
			for (int i = 0; i < wacc_pkg::LIMBS - 1; i++) begin
				acc_q[i] <= acc_q[i+1];
				opb_q[i] <= opb_q[i+1];
			end
			acc_q[wacc_pkg::LIMBS-1] <= res;
			opb_q[wacc_pkg::LIMBS-1] <= b;
		end else if (cmd.single) begin
			if (req_func == wacc_pkg::FN_LOAD_A)
				acc_q[req_limb_index] <= req_value;
			else if (req_func == wacc_pkg::FN_LOAD_B)
				opb_q[req_limb_index] <= req_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q <= req_func;
			val_q  <= req_value;
			cy_q   <= '0;
			ge_q   <= 1'b1;
		end else if (cmd.step) begin
			cy_q <= cy_d;
			ge_q <= ge_d;
			if (func_q == wacc_pkg::FN_ADD_W)
				val_q <= '0;
		end
		if (cmd.single) begin
			data_q      <= (req_func == wacc_pkg::FN_READ) ? acc_q[req_limb_index] : '0;
			ge_out_q    <= 1'b0;
			carry_out_q <= 1'b0;
		end else if (cmd.finish) begin
			data_q      <= '0;
			ge_out_q    <= (func_q == wacc_pkg::FN_CMP) && ge_q;
			carry_out_q <= ((func_q == wacc_pkg::FN_ADD_W || func_q == wacc_pkg::FN_ADD_B)
				&& cy_q[0]) || ((func_q == wacc_pkg::FN_MUL) && (cy_q != '0));
		end
	end

	assign rsp_limb_data = data_q;
	assign rsp_ge        = ge_out_q;
	assign rsp_carry     = carry_out_q;

endmodule

`default_nettype wire

@@ rtl/wide_accumulator_alu_256_core.sv @@
// Channel  Dir  Word
// req      in   func, limb_index, value
// rsp      out  limb_data, greater_or_equal, carry_out
//
// Loads and reads finish at accept. Add, multiply, shift and compare run
// in order: accept, eight limb steps through the shared 32-bit limb unit,
// then the output register load. arst_n clears both 256-bit registers and
// the sequencer. A stalled rsp word holds the block after its limb steps;
// a new req word is taken while the old rsp word is being taken.
// Depends on wacc_pkg, wacc_req_if, wacc_rsp_if, wacc_ctrl, wacc_dp.
`default_nettype none

module wide_accumulator_alu_256_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	wacc_req_if.sink    req,
	wacc_rsp_if.source  rsp
);

	wacc_pkg::cmd_t cmd;

	wacc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	wacc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.req_func       (req.func),
		.req_limb_index (req.limb_index),
		.req_value      (req.value),
		.rsp_limb_data  (rsp.limb_data),
		.rsp_ge         (rsp.greater_or_equal),
		.rsp_carry      (rsp.carry_out)
	);

`ifndef SYNTHESIS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.single, cmd.step, cmd.finish}))
		else $error("more than one datapath command");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !req.ready && cmd.step)
		else $error("limb steps did not follow a start");

	a_no_finish_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !cmd.finish && !cmd.single)
		else $error("output overwritten while stalled");

	a_ready_not_stepping: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !cmd.step)
		else $error("ready while limb steps run");
`endif

endmodule

`default_nettype wire

@@ bench/wide_accumulator_alu_256_core_tb.sv @@
// Regression bench for wide_accumulator_alu_256_core: a directed table, then random op
// sequences, each word checked against its typed row or 256-bit register shadows.
// Depends on wacc_pkg, wacc_req_if, wacc_rsp_if and the core RTL.
module wide_accumulator_alu_256_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wacc_pkg::*;

	localparam int ACC_W       = LIMBS * LIMB_WIDTH;
	localparam int TOTAL_WORDS = 1375;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		limb_t limb_data;
		logic  greater_or_equal;
		logic  carry_out;
	} rsp_word_t;

	typedef struct packed {
		func_t       func;
		idx_t        limb_index;
		logic [31:0] value;
		logic        typed;
		rsp_word_t   want;
	} dir_row_t;

	localparam rsp_word_t NO_FLAGS = '0;
	localparam rsp_word_t GE_SET   = '{32'h0, 1'b1, 1'b0};

	dir_row_t dir_rows [25] = '{
		'{FN_READ,   3'd0, 32'h0000_0000, 1'b1, NO_FLAGS},
		'{FN_CMP,    3'd0, 32'h0000_0000, 1'b1, GE_SET},
		'{FN_ADD_B,  3'd0, 32'h0000_0000, 1'b1, NO_FLAGS},
		'{FN_LOAD_A, 3'd0, 32'hFFFF_FFFF, 1'b1, NO_FLAGS},
		'{FN_ADD_W,  3'd5, 32'hFFFF_FFFF, 1'b1, NO_FLAGS},
		'{FN_READ,   3'd1, 32'h0000_0000, 1'b1, '{32'h0000_0001, 1'b0, 1'b0}},
		'{FN_READ,   3'd0, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFE, 1'b0, 1'b0}},
		'{FN_MUL,    3'd0, 32'h0000_0000, 1'b1, NO_FLAGS},
		'{FN_READ,   3'd1, 32'h0000_0000, 1'b1, NO_FLAGS},
		'{FN_LOAD_A, 3'd7, 32'hFFFF_FFFF, 1'b1, NO_FLAGS},
		'{FN_MUL,    3'd0, 32'hFFFF_FFFF, 1'b0, NO_FLAGS},
		'{FN_SHL,    3'd0, 32'hFFFF_FFE0, 1'b0, NO_FLAGS},
		'{FN_SHL,    3'd0, 32'h0000_001F, 1'b0, NO_FLAGS},
		'{FN_READ,   3'd7, 32'h0000_0000, 1'b0, NO_FLAGS},
		'{FN_LOAD_B, 3'd7, 32'hFFFF_FFFF, 1'b1, NO_FLAGS},
		'{FN_CMP,    3'd0, 32'h0000_0000, 1'b0, NO_FLAGS},
		'{FN_LOAD_B, 3'd0, 32'hFFFF_FFFF, 1'b1, NO_FLAGS},
		'{FN_ADD_B,  3'd0, 32'h0000_0000, 1'b0, NO_FLAGS},
		'{FN_ADD_W,  3'd2, 32'h0000_0000, 1'b0, NO_FLAGS},
		'{FN_MUL,    3'd0, 32'h0000_0001, 1'b0, NO_FLAGS},
		'{FN_SHL,    3'd0, 32'h0000_0001, 1'b0, NO_FLAGS},
		'{FN_READ,   3'd6, 32'h0000_0000, 1'b0, NO_FLAGS},
		'{FN_LOAD_A, 3'd3, 32'h8000_0001, 1'b1, NO_FLAGS},
		'{FN_READ,   3'd3, 32'h0000_0000, 1'b1, '{32'h8000_0001, 1'b0, 1'b0}},
		'{FN_CMP,    3'd0, 32'h0000_0000, 1'b0, NO_FLAGS}
	};

	logic clk;
	logic arst_n;

	wacc_req_if req_ch ();
	wacc_rsp_if rsp_ch ();

	wide_accumulator_alu_256_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [ACC_W-1:0] acc_shadow;
	logic [ACC_W-1:0] opb_shadow;
	rsp_word_t        words_due [$];
	int               errors      = 0;
	int               cycle_count = 0;
	int               words_sent  = 0;
	bit               steady      = 1'b0;

	function automatic rsp_word_t execute_op(func_t f, idx_t i, logic [31:0] v);
		rsp_word_t           w;
		logic [ACC_W:0]      sum;
		logic [ACC_W+31:0]   prod;
		w = '0;
		case (f)
			FN_LOAD_A: acc_shadow[i*LIMB_WIDTH +: LIMB_WIDTH] = v;
			FN_LOAD_B: opb_shadow[i*LIMB_WIDTH +: LIMB_WIDTH] = v;
			FN_ADD_W: begin
				sum = {1'b0, acc_shadow} + {{ACC_W-31{1'b0}}, v};
				acc_shadow = sum[ACC_W-1:0];
				w.carry_out = sum[ACC_W];
			end
			FN_ADD_B: begin
				sum = {1'b0, acc_shadow} + {1'b0, opb_shadow};
				acc_shadow = sum[ACC_W-1:0];
				w.carry_out = sum[ACC_W];
			end
			FN_MUL: begin
				prod = {32'h0, acc_shadow} * {{ACC_W{1'b0}}, v};
				acc_shadow = prod[ACC_W-1:0];
				w.carry_out = |prod[ACC_W+31:ACC_W];
			end
			FN_SHL: acc_shadow = acc_shadow << v[SHAMT_W-1:0];
			FN_CMP: w.greater_or_equal = (acc_shadow >= opb_shadow);
			FN_READ: w.limb_data = acc_shadow[i*LIMB_WIDTH +: LIMB_WIDTH];
			default: ;
		endcase
		return w;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [31:0] pick_limb();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 32'hFFFF_FFFF;
		if (r < 37)
			return 32'h0;
		if (r < 47)
			return 32'h1 << $urandom_range(31);
		return $urandom;
	endfunction

	function automatic func_t pick_arith();
		case ($urandom_range(4))
			0: return FN_ADD_W;
			1: return FN_ADD_B;
			2: return FN_MUL;
			3: return FN_SHL;
			default: return FN_CMP;
		endcase
	endfunction

	task automatic send_word(func_t f, idx_t i, logic [31:0] v,
		bit typed = 1'b0, rsp_word_t want = '0);
		int        gap;
		rsp_word_t w;
		gap = steady ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid      <= 1'b0;
			req_ch.func       <= func_t'($urandom);
			req_ch.limb_index <= idx_t'($urandom);
			req_ch.value      <= $urandom;
		end
		@(negedge clk);
		req_ch.valid      <= 1'b1;
		req_ch.func       <= f;
		req_ch.limb_index <= i;
		req_ch.value      <= v;
		do
			@(posedge clk);
		while (!req_ch.ready);
		w = execute_op(f, i, v);
		words_due.push_back(typed ? want : w);
		words_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (words_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_arith();
		func_t f;
		f = pick_arith();
		if (f == FN_MUL && $urandom_range(1))
			send_word(f, idx_t'($urandom), $urandom_range(16));
		else if (f == FN_SHL)
			send_word(f, idx_t'($urandom), $urandom);
		else
			send_word(f, idx_t'($urandom), pick_limb());
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("wide_accumulator_alu_256_core regression: fail");
			$finish;
		end
	end

	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (stall == 0 && !steady)
				stall = pick_gap();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rsp_word_t got;
		rsp_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.limb_data, rsp_ch.greater_or_equal, rsp_ch.carry_out};
			if (words_due.size() == 0) begin
				$error("response word with none outstanding: %h", got);
				errors++;
			end else begin
				want = words_due.pop_front();
				if (got.limb_data !== want.limb_data) begin
					$error("limb_data: expected %h, got %h", want.limb_data, got.limb_data);
					errors++;
				end
				if (got.greater_or_equal !== want.greater_or_equal) begin
					$error("greater_or_equal: expected %b, got %b",
						want.greater_or_equal, got.greater_or_equal);
					errors++;
				end
				if (got.carry_out !== want.carry_out) begin
					$error("carry_out: expected %b, got %b", want.carry_out, got.carry_out);
					errors++;
				end
			end
		end
	end

	initial begin
		int          kind;
		int          n;
		logic [31:0] v;
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.func       <= FN_LOAD_A;
		req_ch.limb_index <= '0;
		req_ch.value      <= '0;
		acc_shadow = '0;
		opb_shadow = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r])
			send_word(dir_rows[r].func, dir_rows[r].limb_index, dir_rows[r].value,
				dir_rows[r].typed, dir_rows[r].want);
		wait_idle();

		while (words_sent < TOTAL_WORDS) begin
			steady = ($urandom_range(9) == 0);
			kind = $urandom_range(99);
			if (kind < 40) begin
				for (int k = 0; k < LIMBS; k++)
					send_word(FN_LOAD_A, idx_t'(k), pick_limb());
				if ($urandom_range(1))
					for (int k = 0; k < LIMBS; k++)
						send_word(FN_LOAD_B, idx_t'(k), pick_limb());
				n = $urandom_range(5, 1);
				repeat (n) send_arith();
				for (int k = 0; k < LIMBS; k++)
					send_word(FN_READ, idx_t'(k), $urandom);
			end else if (kind < 55) begin
				// all-ones accumulator: every add or multiply wraps
				for (int k = 0; k < LIMBS; k++)
					send_word(FN_LOAD_A, idx_t'(k), 32'hFFFF_FFFF);
				case ($urandom_range(2))
					0: send_word(FN_ADD_W, idx_t'($urandom), $urandom_range(32'hFFFF_FFFF, 1));
					1: begin
						send_word(FN_LOAD_B, 3'd0, $urandom_range(32'hFFFF_FFFF, 1));
						send_word(FN_ADD_B, idx_t'($urandom), $urandom);
					end
					default: send_word(FN_MUL, idx_t'($urandom), $urandom_range(3, 2));
				endcase
				send_word(FN_READ, 3'd0, $urandom);
				send_word(FN_READ, 3'd7, $urandom);
			end else if (kind < 70) begin
				// equal registers, then one limb disturbed
				for (int k = 0; k < LIMBS; k++) begin
					v = pick_limb();
					send_word(FN_LOAD_A, idx_t'(k), v);
					send_word(FN_LOAD_B, idx_t'(k), v);
				end
				send_word(FN_CMP, idx_t'($urandom), $urandom);
				send_word(FN_LOAD_B, idx_t'($urandom), pick_limb());
				send_word(FN_CMP, idx_t'($urandom), $urandom);
				send_word(FN_ADD_B, idx_t'($urandom), $urandom);
				send_word(FN_READ, idx_t'($urandom), $urandom);
			end else if (kind < 90) begin
				n = $urandom_range(10, 4);
				repeat (n) begin
					case ($urandom_range(3))
						0: send_word(FN_READ, idx_t'($urandom), $urandom);
						1: send_word($urandom_range(1) ? FN_LOAD_A : FN_LOAD_B,
							idx_t'($urandom), pick_limb());
						default: send_arith();
					endcase
				end
			end else begin
				n = $urandom_range(5, 1);
				repeat (n) send_word(func_t'($urandom), idx_t'($urandom), $urandom);
			end
			if ($urandom_range(9) == 0)
				wait_idle();
		end
		steady = 1'b0;

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("wide_accumulator_alu_256_core regression: pass");
		else
			$display("wide_accumulator_alu_256_core regression: fail");
		$finish;
	end

endmodule

@@ wide_accumulator_alu_256_core.f @@
rtl/wacc_pkg.sv
rtl/wacc_req_if.sv
rtl/wacc_rsp_if.sv
rtl/wacc_ctrl.sv
rtl/wacc_dp.sv
rtl/wide_accumulator_alu_256_core.sv
bench/wide_accumulator_alu_256_core_tb.sv
